@@ design/ppr_pkg.sv @@
// Shared types and constants for the pinhole primary-ray direction block.
// Used by every module under design/. No dependencies.
`default_nettype none

package ppr_pkg;

  // Coordinate and subpixel widths actually used from the item fields.
  localparam int unsigned COORD_BITS = 16;
  localparam int unsigned SUB_BITS   = 8;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_U_BASIS   = 3'd0,
    CFG_V_BASIS   = 3'd1,
    CFG_W_BASIS   = 3'd2,
    CFG_NEAR      = 3'd3,
    CFG_HALF      = 3'd4,
    CFG_IMG_SIZE  = 3'd5,
    CFG_AA_KERNEL = 3'd6
  } cfg_idx_e;

  // Register widths
  localparam int unsigned COMP_W   = 21;           // Q2.18 basis component
  localparam int unsigned BASIS_W  = 3 * COMP_W;
  localparam int unsigned NEAR_W   = 32;
  localparam int unsigned HALF_W   = 31;
  localparam int unsigned HALFS_W  = 2 * HALF_W;
  localparam int unsigned SIZE_W   = 32;
  localparam int unsigned SIZE_H_LSB = 16;
  localparam int unsigned KERN_W   = 8;
  localparam int unsigned K1_W     = KERN_W + 1;
  localparam logic [NEAR_W-1:0] NEAR_RESET = 32'd429497;

  // Datapath widths
  localparam int unsigned DEN_W    = COORD_BITS + KERN_W;   // size * (K+1)
  localparam int unsigned WGT_W    = 32;                    // Q15.16 weight
  localparam int unsigned DVEC_W   = 55;                    // Q.34 direction comp
  localparam int unsigned MAG_W    = DVEC_W - 1;
  localparam int unsigned NORM_W   = 30;                    // normalized magnitude
  localparam int unsigned SQSUM_W  = 2 * NORM_W + 2;
  localparam int unsigned ROOT_W   = SQSUM_W / 2;
  localparam int unsigned DIR_W    = 32;

  localparam logic [WGT_W-1:0] WGT_MAX = {1'b0, {(WGT_W-1){1'b1}}};
  localparam logic [WGT_W-1:0] WGT_MIN = {1'b1, {(WGT_W-1){1'b0}}};

  typedef struct packed {
    logic [15:0] pixel_x;
    logic [15:0] pixel_y;
    logic [7:0]  sub_x;
    logic [7:0]  sub_y;
  } ray_in_t;

  typedef struct packed {
    logic signed [DIR_W-1:0] dir_x;
    logic signed [DIR_W-1:0] dir_y;
    logic signed [DIR_W-1:0] dir_z;
    logic                    degenerate;
  } ray_out_t;

  // Per-item side flags carried down the pipe
  typedef struct packed {
    logic [2:0] neg;    // component sign
    logic       zero;   // all three components zero
  } ppr_flags_t;

  typedef struct packed {
    ppr_flags_t                  flags;
    logic [2:0][NORM_W-1:0]      mag;
  } ppr_tag_t;

endpackage

`default_nettype wire

@@ design/ppr_weight.sv @@
// Image-plane weight pipeline: position, scaling, bit-per-stage floor divide,
// offset and saturation. Depends on ppr_pkg.
`default_nettype none

module ppr_weight (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                valid_i,
  input  logic signed [ppr_pkg::COORD_BITS:0] coord_i,
  input  logic [ppr_pkg::SUB_BITS-1:0]        sub_i,
  input  logic [ppr_pkg::K1_W-1:0]            k1_i,
  input  logic [ppr_pkg::DEN_W-1:0]           den_i,
  input  logic [ppr_pkg::HALF_W-1:0]          half_i,
  output logic                                valid_o,
  output logic signed [ppr_pkg::WGT_W-1:0]    weight_o
);

  localparam int unsigned POS_W = ppr_pkg::COORD_BITS + 10;
  localparam int unsigned N_W   = POS_W + 32;
  localparam int unsigned QB    = N_W - ppr_pkg::DEN_W;   // quotient bits kept
  localparam int unsigned WGT_W = ppr_pkg::WGT_W;
  localparam int unsigned DEN_W = ppr_pkg::DEN_W;

  // stage 0: sample position in 1/(K+1) units
  logic signed [POS_W-1:0] c_ext, k_ext, s_ext, pos_d, pos_q;
  logic                    vld0_q;
  assign c_ext = POS_W'(coord_i);
  assign k_ext = POS_W'(k1_i);
  assign s_ext = POS_W'(sub_i);
  assign pos_d = c_ext * k_ext + s_ext + POS_W'(1);

  // stage 1: 2*half*pos
  logic signed [N_W-1:0] h_ext, p_ext, n_d, n_q;
  logic                  vld1_q;
  assign h_ext = N_W'(half_i);
  assign p_ext = N_W'(pos_q);
  assign n_d   = (h_ext * p_ext) <<< 1;

  // stage 2: magnitude, overflow check, divider seed
  logic             neg2;
  logic [N_W-1:0]   mag2;
  assign neg2 = n_q[N_W-1];
  assign mag2 = neg2 ? -n_q : n_q;

  logic [DEN_W-1:0] rem_q [QB+1];
  logic [QB-1:0]    low_q [QB+1];
  logic [QB-1:0]    quo_q [QB+1];
  logic             neg_q [QB+1];
  logic             sat_q [QB+1];
  logic             vld_q [QB+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld0_q   <= 1'b0;
      vld1_q   <= 1'b0;
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld0_q   <= valid_i;
      vld1_q   <= vld0_q;
      vld_q[0] <= vld1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pos_q    <= pos_d;
      n_q      <= n_d;
      rem_q[0] <= mag2[N_W-1:QB];
      low_q[0] <= mag2[QB-1:0];
      quo_q[0] <= '0;
      neg_q[0] <= neg2;
      sat_q[0] <= (mag2[N_W-1:QB] >= den_i);
    end
  end

  // one quotient bit per stage
  for (genvar k = 1; k <= QB; k++) begin : g_div
    logic [DEN_W:0] t;
    logic           ge;
    logic [DEN_W:0] diff;
    assign t    = {rem_q[k-1], low_q[k-1][QB-1]};
    assign ge   = (t >= {1'b0, den_i});
    assign diff = t - {1'b0, den_i};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= ge ? diff[DEN_W-1:0] : t[DEN_W-1:0];
        low_q[k] <= {low_q[k-1][QB-2:0], 1'b0};
        quo_q[k] <= {quo_q[k-1][QB-2:0], ge};
        neg_q[k] <= neg_q[k-1];
        sat_q[k] <= sat_q[k-1];
      end
    end
  end

  // final: floor for negatives, subtract half, saturate
  logic [QB:0]            qm;
  logic signed [QB+2:0]   sv, rv;
  logic                   ovf;
  logic [WGT_W-1:0]       w_d;
  logic                   vldf_q;

  assign qm  = {1'b0, quo_q[QB]} + (QB+1)'(neg_q[QB] & (|rem_q[QB]));
  assign sv  = neg_q[QB] ? -$signed({2'b0, qm}) : $signed({2'b0, qm});
  assign rv  = sv - $signed((QB+3)'(half_i));
  assign ovf = (rv[QB+2:WGT_W-1] != {(QB+4-WGT_W){rv[QB+2]}});

  always_comb begin
    if (sat_q[QB]) begin
      w_d = neg_q[QB] ? ppr_pkg::WGT_MIN : ppr_pkg::WGT_MAX;
    end else if (ovf) begin
      w_d = rv[QB+2] ? ppr_pkg::WGT_MIN : ppr_pkg::WGT_MAX;
    end else begin
      w_d = rv[WGT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vldf_q <= 1'b0;
    end else if (en_i) begin
      vldf_q <= vld_q[QB];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      weight_o <= w_d;
    end
  end

  assign valid_o = vldf_q;

endmodule

`default_nettype wire

@@ design/ppr_vec.sv @@
// Direction vector pipeline: basis products, sum, magnitude, leading-one
// search, normalizing shift and sum of squares. Depends on ppr_pkg.
`default_nettype none

module ppr_vec (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              valid_i,
  input  logic signed [ppr_pkg::WGT_W-1:0]  ax_i,
  input  logic signed [ppr_pkg::WGT_W-1:0]  ay_i,
  input  logic [ppr_pkg::BASIS_W-1:0]       u_i,
  input  logic [ppr_pkg::BASIS_W-1:0]       v_i,
  input  logic [ppr_pkg::BASIS_W-1:0]       w_i,
  input  logic [ppr_pkg::NEAR_W-1:0]        near_i,
  output logic                              valid_o,
  output ppr_pkg::ppr_tag_t                 tag_o,
  output logic [ppr_pkg::SQSUM_W-1:0]       sqsum_o
);

  localparam int unsigned NSTG   = 8;
  localparam int unsigned COMP_W = ppr_pkg::COMP_W;
  localparam int unsigned PU_W   = ppr_pkg::WGT_W + COMP_W;
  localparam int unsigned PW_W   = ppr_pkg::NEAR_W + 1 + COMP_W;
  localparam int unsigned DVEC_W = ppr_pkg::DVEC_W;
  localparam int unsigned MAG_W  = ppr_pkg::MAG_W;
  localparam int unsigned NORM_W = ppr_pkg::NORM_W;
  localparam int unsigned NG     = (MAG_W + 7) / 8;
  localparam int unsigned LZ_W   = $clog2(NG * 8);
  localparam int unsigned SQ_W   = 2 * NORM_W;
  localparam int unsigned SQSUM_W = ppr_pkg::SQSUM_W;

  logic [NSTG-1:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[NSTG-2:0], valid_i};
    end
  end
  assign valid_o = vld_q[NSTG-1];

  // V1: products
  logic signed [COMP_W-1:0]   uc [3], vc [3], wc [3];
  logic signed [ppr_pkg::NEAR_W:0] nr;
  logic signed [PU_W-1:0]     pu_d [3], pv_d [3], pu_q [3], pv_q [3];
  logic signed [PW_W-1:0]     pw_d [3], pw_q [3];

  assign nr = $signed({1'b0, near_i});

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      uc[j]   = u_i[j*COMP_W +: COMP_W];
      vc[j]   = v_i[j*COMP_W +: COMP_W];
      wc[j]   = w_i[j*COMP_W +: COMP_W];
      pu_d[j] = ax_i * uc[j];
      pv_d[j] = ay_i * vc[j];
      pw_d[j] = nr * wc[j];
    end
  end

  // V2: component sum, near term floored to Q.34
  logic signed [DVEC_W-1:0] d_d [3], d_q [3];
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      d_d[j] = DVEC_W'(pu_q[j]) + DVEC_W'(pv_q[j]) + DVEC_W'(pw_q[j] >>> 16);
    end
  end

  // V3: sign and magnitude
  logic [DVEC_W-1:0]  ad [3];
  logic [MAG_W-1:0]   mag3_d [3], mag3_q [3];
  logic [MAG_W-1:0]   or3_d, or3_q;
  logic [2:0]         neg3_d;
  ppr_pkg::ppr_flags_t fl3_q, fl4_q, fl5_q, fl6_q, fl7_q;

  always_comb begin
    or3_d = '0;
    for (int j = 0; j < 3; j++) begin
      neg3_d[j] = d_q[j][DVEC_W-1];
      ad[j]     = neg3_d[j] ? -d_q[j] : d_q[j];
      mag3_d[j] = ad[j][MAG_W-1:0];
      or3_d     = or3_d | mag3_d[j];
    end
  end

  // V4: per-byte leading-one
  logic [NG*8-1:0]  orp;
  logic [NG-1:0]    nz_d, nz_q;
  logic [2:0]       gpos_d [NG], gpos_q [NG];
  logic [MAG_W-1:0] mag4_q [3];

  assign orp = (NG*8)'(or3_q);
  always_comb begin
    for (int g = 0; g < NG; g++) begin
      nz_d[g]   = |orp[g*8 +: 8];
      gpos_d[g] = '0;
      for (int b = 0; b < 8; b++) begin
        if (orp[g*8+b]) gpos_d[g] = 3'(b);
      end
    end
  end

  // V5: pick the highest nonzero byte
  logic [LZ_W-1:0]  p_d, p_q;
  logic [MAG_W-1:0] mag5_q [3];
  always_comb begin
    p_d = '0;
    for (int g = 0; g < NG; g++) begin
      if (nz_q[g]) p_d = LZ_W'(g * 8) + LZ_W'(gpos_q[g]);
    end
  end

  // V6: shift so the top set bit lands on NORM_W-1
  localparam logic [LZ_W-1:0] TOP = LZ_W'(NORM_W - 1);
  logic [MAG_W-1:0]  sh [3];
  logic [NORM_W-1:0] nm_d [3], nm_q [3];
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      if (p_q >= TOP) begin
        sh[j] = mag5_q[j] >> (p_q - TOP);
      end else begin
        sh[j] = mag5_q[j] << (TOP - p_q);
      end
      nm_d[j] = sh[j][NORM_W-1:0];
    end
  end

  // V7: squares
  logic [SQ_W-1:0]   sq_d [3], sq_q [3];
  logic [NORM_W-1:0] nm7_q [3];
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      sq_d[j] = nm_q[j] * nm_q[j];
    end
  end

  // V8: sum of squares
  logic [SQSUM_W-1:0] ss_d;
  assign ss_d = SQSUM_W'(sq_q[0]) + SQSUM_W'(sq_q[1]) + SQSUM_W'(sq_q[2]);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int j = 0; j < 3; j++) begin
        pu_q[j]   <= pu_d[j];
        pv_q[j]   <= pv_d[j];
        pw_q[j]   <= pw_d[j];
        d_q[j]    <= d_d[j];
        mag3_q[j] <= mag3_d[j];
        mag4_q[j] <= mag3_q[j];
        mag5_q[j] <= mag4_q[j];
        nm_q[j]   <= nm_d[j];
        sq_q[j]   <= sq_d[j];
        nm7_q[j]  <= nm_q[j];
      end
      for (int g = 0; g < NG; g++) begin
        gpos_q[g] <= gpos_d[g];
      end
      or3_q      <= or3_d;
      fl3_q.neg  <= neg3_d;
      fl3_q.zero <= (or3_d == '0);
      nz_q       <= nz_d;
      fl4_q      <= fl3_q;
      p_q        <= p_d;
      fl5_q      <= fl4_q;
      fl6_q      <= fl5_q;
      fl7_q      <= fl6_q;
      sqsum_o    <= ss_d;
      tag_o.flags <= fl7_q;
      for (int j = 0; j < 3; j++) begin
        tag_o.mag[j] <= nm7_q[j];
      end
    end
  end

endmodule

`default_nettype wire

@@ design/ppr_isqrt.sv @@
// Pipelined integer square root, one root bit per stage, side tag carried
// along. Depends on ppr_pkg.
`default_nettype none

module ppr_isqrt (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         valid_i,
  input  logic [ppr_pkg::SQSUM_W-1:0]  rad_i,
  input  ppr_pkg::ppr_tag_t            tag_i,
  output logic                         valid_o,
  output logic [ppr_pkg::ROOT_W-1:0]   root_o,
  output ppr_pkg::ppr_tag_t            tag_o
);

  localparam int unsigned RW    = ppr_pkg::ROOT_W;
  localparam int unsigned SW    = ppr_pkg::SQSUM_W;
  localparam int unsigned REM_W = RW + 2;

  logic [REM_W-1:0]   rem_q  [RW];
  logic [RW-1:0]      root_q [RW];
  logic [SW-1:0]      rad_q  [RW];
  ppr_pkg::ppr_tag_t  tag_q  [RW];
  logic               vld_q  [RW];

  for (genvar k = 0; k < RW; k++) begin : g_stage
    logic [REM_W-1:0]  rem_in;
    logic [RW-1:0]     root_in;
    logic [SW-1:0]     rad_in;
    ppr_pkg::ppr_tag_t tag_in;
    logic              vld_in;
    logic [REM_W+1:0]  shifted, trial, diff;
    logic              ge;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad_i;
      assign tag_in  = tag_i;
      assign vld_in  = valid_i;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign rad_in  = rad_q[k-1];
      assign tag_in  = tag_q[k-1];
      assign vld_in  = vld_q[k-1];
    end

    assign shifted = {rem_in, rad_in[SW-1:SW-2]};
    assign trial   = (REM_W+2)'({root_in, 2'b01});
    assign ge      = (shifted >= trial);
    assign diff    = shifted - trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= ge ? diff[REM_W-1:0] : shifted[REM_W-1:0];
        root_q[k] <= {root_in[RW-2:0], ge};
        rad_q[k]  <= {rad_in[SW-3:0], 2'b00};
        tag_q[k]  <= tag_in;
      end
    end
  end

  assign valid_o = vld_q[RW-1];
  assign root_o  = root_q[RW-1];
  assign tag_o   = tag_q[RW-1];

endmodule

`default_nettype wire

@@ design/ppr_div.sv @@
// Three parallel pipelined dividers, (mag << 30) / len, one quotient bit per
// stage. Depends on ppr_pkg.
`default_nettype none

module ppr_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            en_i,
  input  logic                            valid_i,
  input  logic [ppr_pkg::ROOT_W-1:0]      len_i,
  input  ppr_pkg::ppr_tag_t               tag_i,
  output logic                            valid_o,
  output logic [2:0][ppr_pkg::ROOT_W-1:0] quo_o,
  output ppr_pkg::ppr_flags_t             flags_o
);

  localparam int unsigned RW = ppr_pkg::ROOT_W;
  localparam int unsigned NW = ppr_pkg::NORM_W;

  logic [2:0][RW-1:0]   rem_q [RW];
  logic [2:0][RW-1:0]   low_q [RW];
  logic [2:0][RW-1:0]   quo_q [RW];
  logic [RW-1:0]        len_q [RW];
  ppr_pkg::ppr_flags_t  flg_q [RW];
  logic                 vld_q [RW];

  for (genvar k = 0; k < RW; k++) begin : g_stage
    logic [2:0][RW-1:0]  rem_in, low_in, quo_in, rem_d;
    logic [RW-1:0]       len_in;
    ppr_pkg::ppr_flags_t flg_in;
    logic                vld_in;
    logic [2:0]          ge;

    if (k == 0) begin : g_first
      always_comb begin
        for (int j = 0; j < 3; j++) begin
          rem_in[j] = RW'(tag_i.mag[j][NW-1:1]);
          low_in[j] = {tag_i.mag[j][0], {(RW-1){1'b0}}};
          quo_in[j] = '0;
        end
      end
      assign len_in = len_i;
      assign flg_in = tag_i.flags;
      assign vld_in = valid_i;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign low_in = low_q[k-1];
      assign quo_in = quo_q[k-1];
      assign len_in = len_q[k-1];
      assign flg_in = flg_q[k-1];
      assign vld_in = vld_q[k-1];
    end

    always_comb begin
      for (int j = 0; j < 3; j++) begin
        logic [RW:0] t, diff;
        t        = {rem_in[j], low_in[j][RW-1]};
        diff     = t - {1'b0, len_in};
        ge[j]    = (t >= {1'b0, len_in});
        rem_d[j] = ge[j] ? diff[RW-1:0] : t[RW-1:0];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        for (int j = 0; j < 3; j++) begin
          rem_q[k][j] <= rem_d[j];
          low_q[k][j] <= {low_in[j][RW-2:0], 1'b0};
          quo_q[k][j] <= {quo_in[j][RW-2:0], ge[j]};
        end
        len_q[k] <= len_in;
        flg_q[k] <= flg_in;
      end
    end
  end

  assign valid_o = vld_q[RW-1];
  assign quo_o   = quo_q[RW-1];
  assign flags_o = flg_q[RW-1];

endmodule

`default_nettype wire

@@ design/pinhole_primary_ray_direction.sv @@
// Top level of the pinhole primary-ray direction generator: config registers,
// pipeline enable, output register. Depends on ppr_pkg, ppr_weight, ppr_vec,
// ppr_isqrt and ppr_div.
`default_nettype none

// Channel   | Signals                                   | Item
// ----------+-------------------------------------------+---------------------------
// in        | in_valid_i / in_ready_o / in_i            | pixel, row, sub sample x/y
// out       | out_valid_o / out_ready_i / out_o         | dir x/y/z Q2.30, degenerate
// cfg       | cfg_valid_i / cfg_ready_o / cfg_index_i,  | register index, write data
//           | cfg_data_i                                |
//
// One item accepted per cycle while the pipe is not stalled. Items pass through the weight
// divide, the vector pipe, the square root, the divide and the output register. The
// bit-per-stage dividers and square root set the depth.
// Reset clears all valid bits and loads the register reset values; no clear pass.
// All stages before the output register share one enable. The pipe only stalls when the output register
// holds an item that is not taken and the last stage also holds one.
// The cfg port is always ready.

module pinhole_primary_ray_direction (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  ppr_pkg::ray_in_t                    in_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output ppr_pkg::ray_out_t                   out_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [ppr_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [ppr_pkg::CFG_DATA_W-1:0]      cfg_data_i
);

  localparam int unsigned CB = ppr_pkg::COORD_BITS;

  // ---------------------------------------------------------------- config
  logic [ppr_pkg::BASIS_W-1:0] u_q, v_q, w_q;
  logic [ppr_pkg::NEAR_W-1:0]  near_q;
  logic [ppr_pkg::HALFS_W-1:0] half_q;
  logic [ppr_pkg::SIZE_W-1:0]  size_q;
  logic [ppr_pkg::KERN_W-1:0]  kern_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      u_q    <= '0;
      v_q    <= '0;
      w_q    <= '0;
      near_q <= ppr_pkg::NEAR_RESET;
      half_q <= '0;
      size_q <= '0;
      kern_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (ppr_pkg::cfg_idx_e'(cfg_index_i))
        ppr_pkg::CFG_U_BASIS:   u_q    <= cfg_data_i[ppr_pkg::BASIS_W-1:0];
        ppr_pkg::CFG_V_BASIS:   v_q    <= cfg_data_i[ppr_pkg::BASIS_W-1:0];
        ppr_pkg::CFG_W_BASIS:   w_q    <= cfg_data_i[ppr_pkg::BASIS_W-1:0];
        ppr_pkg::CFG_NEAR:      near_q <= cfg_data_i[ppr_pkg::NEAR_W-1:0];
        ppr_pkg::CFG_HALF:      half_q <= cfg_data_i[ppr_pkg::HALFS_W-1:0];
        ppr_pkg::CFG_IMG_SIZE:  size_q <= cfg_data_i[ppr_pkg::SIZE_W-1:0];
        ppr_pkg::CFG_AA_KERNEL: kern_q <= cfg_data_i[ppr_pkg::KERN_W-1:0];
        default: ;  // unknown index: write dropped
      endcase
    end
  end

  logic [CB-1:0] width, height;
  logic          size_zero;
  assign width     = size_q[CB-1:0];
  assign height    = size_q[ppr_pkg::SIZE_H_LSB +: CB];
  assign size_zero = (width == '0) || (height == '0);

  // Divisors follow the config registers directly; small 16 x 9 products.
  logic [ppr_pkg::K1_W-1:0]  k1;
  logic [ppr_pkg::DEN_W-1:0] den_x, den_y;
  assign k1    = ppr_pkg::K1_W'(kern_q) + ppr_pkg::K1_W'(1);
  assign den_x = ppr_pkg::DEN_W'(width) * ppr_pkg::DEN_W'(k1);
  assign den_y = ppr_pkg::DEN_W'(height) * ppr_pkg::DEN_W'(k1);

  // ---------------------------------------------------------------- enable
  logic en, last_valid;
  assign en         = !last_valid || !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  // ---------------------------------------------------------------- weights
  logic signed [CB:0] cx, cy;
  assign cx = $signed({1'b0, width}) - $signed({1'b0, in_i.pixel_x[CB-1:0]});
  assign cy = $signed({1'b0, in_i.pixel_y[CB-1:0]});

  logic                            wx_valid, wy_valid;
  logic signed [ppr_pkg::WGT_W-1:0] ax, ay;

  ppr_weight u_wx (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (in_valid_i),
    .coord_i  (cx),
    .sub_i    (in_i.sub_x[ppr_pkg::SUB_BITS-1:0]),
    .k1_i     (k1),
    .den_i    (den_x),
    .half_i   (half_q[ppr_pkg::HALF_W-1:0]),
    .valid_o  (wx_valid),
    .weight_o (ax)
  );

  ppr_weight u_wy (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (in_valid_i),
    .coord_i  (cy),
    .sub_i    (in_i.sub_y[ppr_pkg::SUB_BITS-1:0]),
    .k1_i     (k1),
    .den_i    (den_y),
    .half_i   (half_q[ppr_pkg::HALF_W +: ppr_pkg::HALF_W]),
    .valid_o  (wy_valid),
    .weight_o (ay)
  );

  // ---------------------------------------------------------------- vector
  logic                          vec_valid;
  ppr_pkg::ppr_tag_t             vec_tag;
  logic [ppr_pkg::SQSUM_W-1:0]   sqsum;

  ppr_vec u_vec (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (wx_valid & wy_valid),
    .ax_i    (ax),
    .ay_i    (ay),
    .u_i     (u_q),
    .v_i     (v_q),
    .w_i     (w_q),
    .near_i  (near_q),
    .valid_o (vec_valid),
    .tag_o   (vec_tag),
    .sqsum_o (sqsum)
  );

  // ---------------------------------------------------------------- length
  logic                        sq_valid;
  logic [ppr_pkg::ROOT_W-1:0]  len;
  ppr_pkg::ppr_tag_t           sq_tag;

  ppr_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vec_valid),
    .rad_i   (sqsum),
    .tag_i   (vec_tag),
    .valid_o (sq_valid),
    .root_o  (len),
    .tag_o   (sq_tag)
  );

  // ---------------------------------------------------------------- divide
  logic [2:0][ppr_pkg::ROOT_W-1:0] quo;
  ppr_pkg::ppr_flags_t             flags;

  ppr_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sq_valid),
    .len_i   (len),
    .tag_i   (sq_tag),
    .valid_o (last_valid),
    .quo_o   (quo),
    .flags_o (flags)
  );

  // ---------------------------------------------------------------- output
  // Sign restore; zero vector or zero image size forces a degenerate item.
  logic [ppr_pkg::DIR_W-1:0] dir [3];
  logic                      degen;
  assign degen = flags.zero || size_zero;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      logic [ppr_pkg::DIR_W-1:0] qe;
      qe = ppr_pkg::DIR_W'(quo[j]);
      if (degen) begin
        dir[j] = '0;
      end else begin
        dir[j] = flags.neg[j] ? -qe : qe;
      end
    end
  end

  logic out_valid_q;
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || out_ready_i) begin
      out_valid_q <= last_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((!out_valid_q || out_ready_i) && last_valid) begin
      out_o.dir_x      <= dir[0];
      out_o.dir_y      <= dir[1];
      out_o.dir_z      <= dir[2];
      out_o.degenerate <= degen;
    end
  end

endmodule

`default_nettype wire
